// ===== sv/sound_command_latch_and_sample_feeder_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef SOUND_COMMAND_LATCH_AND_SAMPLE_FEEDER_DEFINES_SVH
`define SOUND_COMMAND_LATCH_AND_SAMPLE_FEEDER_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define SCSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted during reset.
`define SCSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/scsf_pkg.sv =====
package scsf_pkg;

   // Item commands
   localparam logic [2:0] CMD_MAIN_WR  = 3'd0;
   localparam logic [2:0] CMD_SOUND_WR = 3'd1;
   localparam logic [2:0] CMD_SOUND_RD = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_ROM_LOAD = 3'd4;

   // Bus addresses
   localparam logic [15:0] ADDR_CMD_HI   = 16'ha800;
   localparam logic [15:0] ADDR_CMD_LO   = 16'ha801;
   localparam logic [15:0] ADDR_FLIP     = 16'ha802;
   localparam logic [15:0] ADDR_SMP_NUM  = 16'h7004;
   localparam logic [15:0] ADDR_TRIGGER  = 16'h7006;
   localparam logic [15:0] ADDR_CODE_RD  = 16'h7000;

   localparam int ROM_INDEX_W = 13;

   typedef struct packed {
      logic [7:0]             read_data;
      logic                   mute;
      logic                   flip;
      logic [ROM_INDEX_W-1:0] rom_index;
      logic [2:0]             bit_sel;
   } lat_stat_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       strobe;
      logic       mute;
      logic       flip;
      logic [2:0] bit_sel;
      logic       in_range;
   } s1_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       cvsd_bit;
      logic       cvsd_strobe;
      logic       mute;
      logic       flip;
   } out_type;

   // Lowest set bit i among bits 6-15 gives 16 - i; none set gives 0.
   function automatic logic [3:0] high_code_of(input logic [15:0] w);
      logic [3:0] c;
      c = '0;
      for (int i = 15; i >= 6; i--) begin
         if (w[i]) c = 4'(16 - i);
      end
      return c;
   endfunction

   // Highest set bit h among bits 0-5 gives 5 - h.
   function automatic logic [3:0] low_code_of(input logic [5:0] b);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i <= 5; i++) begin
         if (b[i]) c = 4'(5 - i);
      end
      return c;
   endfunction

endpackage

// ===== sv/scsf_if.sv =====
interface scsf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] bus_address;
   logic [7:0]  bus_data;

   modport source (output valid, output cmd, output bus_address, output bus_data,
                   input ready);
   modport sink   (input valid, input cmd, input bus_address, input bus_data,
                   output ready);
endinterface

interface scsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       cvsd_bit;
   logic       cvsd_strobe;
   logic       mute;
   logic       flip;

   modport source (output valid, output read_data, output cvsd_bit,
                   output cvsd_strobe, output mute, output flip, input ready);
   modport sink   (input valid, input read_data, input cvsd_bit,
                   input cvsd_strobe, input mute, input flip, output ready);
endinterface

// ===== sv/scsf_latch.sv =====
module scsf_latch (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [2:0]           cmd,
   input  logic [15:0]          bus_address,
   input  logic [7:0]           bus_data,
   output scsf_pkg::lat_stat_type stat
);

   logic [15:0] cmd_word_ff, cmd_word_in;
   logic [15:0] prev_cmd_ff, prev_cmd_in;
   logic [3:0]  high_code_ff, high_code_in;
   logic [3:0]  low_code_ff, low_code_in;
   logic [7:0]  smp_num_ff, smp_num_in;
   logic [15:0] bit_addr_ff, bit_addr_in;
   logic        mute_ff, mute_in;
   logic        flip_ff, flip_in;
   logic        upd_codes;

   always_comb begin
      cmd_word_in  = cmd_word_ff;
      prev_cmd_in  = prev_cmd_ff;
      high_code_in = high_code_ff;
      low_code_in  = low_code_ff;
      smp_num_in   = smp_num_ff;
      bit_addr_in  = bit_addr_ff;
      mute_in      = mute_ff;
      flip_in      = flip_ff;
      upd_codes    = 1'b0;
      if (fire) begin
         case (cmd)
            scsf_pkg::CMD_MAIN_WR: begin
               if (bus_address == scsf_pkg::ADDR_CMD_HI) begin
                  cmd_word_in = {bus_data, cmd_word_ff[7:0]};
                  upd_codes   = 1'b1;
               end else if (bus_address == scsf_pkg::ADDR_CMD_LO) begin
                  prev_cmd_in = cmd_word_ff;
                  cmd_word_in = {cmd_word_ff[15:8], bus_data};
                  upd_codes   = 1'b1;
               end else if (bus_address == scsf_pkg::ADDR_FLIP) begin
                  flip_in = bus_data[7];
               end
            end
            scsf_pkg::CMD_SOUND_WR: begin
               if (bus_address == scsf_pkg::ADDR_SMP_NUM) begin
                  smp_num_in = bus_data;
               end else if (bus_address == scsf_pkg::ADDR_TRIGGER) begin
                  // trigger: with bit 7 set, restart playback at number*256 and clear the low code; bit 7 clear mutes
                  if (bus_data[7]) begin
                     low_code_in = '0;
                     bit_addr_in = {smp_num_ff, 8'h00};
                  end
                  mute_in = ~bus_data[7];
               end
            end
            scsf_pkg::CMD_TICK: begin
               bit_addr_in = bit_addr_ff + 16'd1;
            end
            default: begin
            end
         endcase
      end
      if (upd_codes) begin
         high_code_in = scsf_pkg::high_code_of(cmd_word_in);
         if (cmd_word_in[5:0] != 6'd0 && cmd_word_in[5:0] != prev_cmd_in[5:0]) begin
            low_code_in = scsf_pkg::low_code_of(cmd_word_in[5:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_word_ff  <= '0;
         prev_cmd_ff  <= '0;
         high_code_ff <= '0;
         low_code_ff  <= '0;
         smp_num_ff   <= '0;
         bit_addr_ff  <= '0;
         mute_ff      <= 1'b1;
         flip_ff      <= 1'b0;
      end else begin
         cmd_word_ff  <= cmd_word_in;
         prev_cmd_ff  <= prev_cmd_in;
         high_code_ff <= high_code_in;
         low_code_ff  <= low_code_in;
         smp_num_ff   <= smp_num_in;
         bit_addr_ff  <= bit_addr_in;
         mute_ff      <= mute_in;
         flip_ff      <= flip_in;
      end
   end

   always_comb begin
      stat.read_data = 8'h00;
      if (cmd == scsf_pkg::CMD_SOUND_RD && bus_address == scsf_pkg::ADDR_CODE_RD) begin
         stat.read_data = {low_code_ff, high_code_ff};
      end
      stat.mute      = mute_in;
      stat.flip      = flip_in;
      stat.rom_index = bit_addr_ff[15:3];
      stat.bit_sel   = bit_addr_ff[2:0];
   end

endmodule

// ===== sv/scsf_rom.sv =====
module scsf_rom #(
   parameter int SAMPLE_ROM_BYTES = 8192
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(SAMPLE_ROM_BYTES)-1:0] wr_addr,
   input  logic [7:0]                          wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(SAMPLE_ROM_BYTES)-1:0] rd_addr,
   output logic [7:0]                          rd_data
);

   logic [7:0] mem [SAMPLE_ROM_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sound_command_latch_and_sample_feeder.sv =====
// Channel   Dir  Transfer                   Payload
// req_chan  in   valid & ready              cmd, bus_address, bus_data
// rsp_chan  out  valid & ready              read_data, cvsd_bit, cvsd_strobe, mute, flip
//
// One item per cycle sustained while rsp_chan is not stalled; each result passes
// through stage 1 and then the output register before it is offered on rsp_chan.
// The sample ROM read (a synchronous read port) sets the two-stage pipeline.
// Reset is synchronous and clears control state; the sample ROM keeps its contents.
// A stalled result holds the output register; one more item waits in stage 1,
// then req_chan.ready drops until the output drains.
`include "sound_command_latch_and_sample_feeder_defines.svh"

module sound_command_latch_and_sample_feeder #(
   parameter int SAMPLE_ROM_BYTES = 8192
) (
   input  logic              clock,
   input  logic              reset,
   scsf_req_if.sink          req_chan,
   scsf_rsp_if.source        rsp_chan
);

   localparam int ADDR_W = $clog2(SAMPLE_ROM_BYTES);

   scsf_pkg::lat_stat_type lat_stat;
   scsf_pkg::s1_type       s1_ff, s1_in;
   scsf_pkg::out_type      out_ff, out_in;
   logic                   s1_v_ff;
   logic                   out_v_ff;
   logic                   fire;
   logic                   advance;
   logic                   is_tick;
   logic                   rom_wr_en;
   logic [7:0]             rom_q;

   // Advance the output whenever it is empty or being taken.
   assign advance        = ~out_v_ff | rsp_chan.ready;
   assign req_chan.ready = ~s1_v_ff | advance;
   assign fire           = req_chan.valid & req_chan.ready;
   assign is_tick        = req_chan.cmd == scsf_pkg::CMD_TICK;

   // Drop ROM loads that land beyond the configured size.
   assign rom_wr_en = fire && req_chan.cmd == scsf_pkg::CMD_ROM_LOAD &&
                      32'(req_chan.bus_address) < SAMPLE_ROM_BYTES;

   scsf_latch u_latch (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cmd         (req_chan.cmd),
      .bus_address (req_chan.bus_address),
      .bus_data    (req_chan.bus_data),
      .stat        (lat_stat)
   );

   scsf_rom #(
      .SAMPLE_ROM_BYTES (SAMPLE_ROM_BYTES)
   ) u_rom (
      .clock   (clock),
      .wr_en   (rom_wr_en),
      .wr_addr (req_chan.bus_address[ADDR_W-1:0]),
      .wr_data (req_chan.bus_data),
      .rd_en   (fire & is_tick),
      .rd_addr (lat_stat.rom_index[ADDR_W-1:0]),
      .rd_data (rom_q)
   );

   // Stage 1: everything but the sample bit, which arrives from the ROM next cycle.
   always_comb begin
      s1_in.read_data = lat_stat.read_data;
      s1_in.strobe    = is_tick;
      s1_in.mute      = lat_stat.mute;
      s1_in.flip      = lat_stat.flip;
      s1_in.bit_sel   = lat_stat.bit_sel;
      s1_in.in_range  = 32'(lat_stat.rom_index) < SAMPLE_ROM_BYTES;
   end

   // Output stage: pick the sample bit, MSB of each byte first.
   always_comb begin
      out_in.read_data   = s1_ff.read_data;
      out_in.cvsd_bit    = s1_ff.strobe & s1_ff.in_range & rom_q[~s1_ff.bit_sel];
      out_in.cvsd_strobe = s1_ff.strobe;
      out_in.mute        = s1_ff.mute;
      out_in.flip        = s1_ff.flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (fire) begin
            s1_v_ff <= 1'b1;
         end else if (advance) begin
            s1_v_ff <= 1'b0;
         end
         if (advance) begin
            out_v_ff <= s1_v_ff;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (fire) s1_ff <= s1_in;
      if (advance && s1_v_ff) out_ff <= out_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.read_data   = out_ff.read_data;
   assign rsp_chan.cvsd_bit    = out_ff.cvsd_bit;
   assign rsp_chan.cvsd_strobe = out_ff.cvsd_strobe;
   assign rsp_chan.mute        = out_ff.mute;
   assign rsp_chan.flip        = out_ff.flip;

   `SCSF_ASSERT_NOW(a_full_stall_blocks_req, clock, reset, s1_v_ff && out_v_ff && !rsp_chan.ready, !req_chan.ready, "request taken with both stages held")
   `SCSF_ASSERT_NEXT(a_tick_loads_strobe, clock, reset, fire && is_tick, s1_v_ff && s1_ff.strobe, "tick transfer did not reach stage 1 as a strobe")
   `SCSF_ASSERT_NEXT(a_trigger_unmutes, clock, reset, fire && req_chan.cmd == scsf_pkg::CMD_SOUND_WR && req_chan.bus_address == scsf_pkg::ADDR_TRIGGER && req_chan.bus_data[7], !s1_ff.mute, "trigger write left decoder muted")
   `SCSF_ASSERT_NOW(a_bit_needs_strobe, clock, reset, rsp_chan.valid && !rsp_chan.cvsd_strobe, !rsp_chan.cvsd_bit, "sample bit set without strobe")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // Size the sample ROM image to match the block's default.
   localparam int ROM_BYTES     = 8192;
   localparam int RANDOM_ITEMS  = 600;
   localparam int PHASES        = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 40;
   localparam int WRAP_TICKS    = 260;

   // Command codes the block treats as no-ops.
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   // Full-scale sample number: playback starts 256 bits below the address wrap.
   localparam logic [7:0] LAST_SAMPLE = 8'hff;

   logic clock;
   logic reset;

   scsf_req_if req_chan ();
   scsf_rsp_if rsp_chan ();

   sound_command_latch_and_sample_feeder #(
      .SAMPLE_ROM_BYTES(ROM_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // One row of the directed stimulus. Rows marked known carry a hand-written
   // result; all others take the predictor's answer.
   typedef struct {
      logic [2:0]        cmd;
      logic [15:0]       addr;
      logic [7:0]        data;
      bit                known;
      scsf_pkg::out_type want;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the sound link after reset.
   // ---------------------------------------------------------------------
   logic [15:0] cmd_word;
   logic [15:0] prev_cmd_word;
   logic [3:0]  hi_code;
   logic [3:0]  lo_code;
   logic [7:0]  smp_num;
   logic [15:0] bit_addr;
   logic        mute_lvl;
   logic        flip_lvl;
   logic [7:0]  rom_img    [ROM_BYTES];
   bit          rom_loaded [ROM_BYTES];

   // Results owed by the block, oldest first.
   scsf_pkg::out_type due_results [$];
   stim_row_type      dir_rows [$];

   int          send_idle_pct;
   int          stall_pct;
   int          items_sent;
   int          mismatch_count;
   int          cycle_count;

   int          send_idle_by_phase [PHASES] = '{0, 45, 0, 9};
   int          stall_by_phase     [PHASES] = '{0, 0, 45, 9};
   logic [15:0] bus_addr_pool [6] = '{scsf_pkg::ADDR_CMD_HI, scsf_pkg::ADDR_CMD_LO,
                                      scsf_pkg::ADDR_FLIP, scsf_pkg::ADDR_SMP_NUM,
                                      scsf_pkg::ADDR_TRIGGER, scsf_pkg::ADDR_CODE_RD};

   // Rebuild both codes after a command write. The low code holds its value
   // unless the low six bits are nonzero and differ from the previous command.
   function automatic void refresh_codes();
      int h;
      int i;
      if (cmd_word[5:0] != 6'd0 && cmd_word[5:0] != prev_cmd_word[5:0]) begin
         h = 5;
         while (!cmd_word[h]) h--;
         lo_code = 4'(5 - h);
      end
      i = 6;
      while (i < 16 && !cmd_word[i]) i++;
      hi_code = (i == 16) ? 4'd0 : 4'(16 - i);
   endfunction

   // Apply one transfer to the predictor and return what the block must emit.
   function automatic scsf_pkg::out_type sound_link_result(input logic [2:0]  c,
                                                           input logic [15:0] a,
                                                           input logic [7:0]  d);
      scsf_pkg::out_type r;
      logic [12:0] idx;
      r = '0;
      case (c)
         scsf_pkg::CMD_MAIN_WR: begin
            if (a == scsf_pkg::ADDR_CMD_HI) begin
               cmd_word[15:8] = d;
               refresh_codes();
            end else if (a == scsf_pkg::ADDR_CMD_LO) begin
               prev_cmd_word = cmd_word;
               cmd_word[7:0] = d;
               refresh_codes();
            end else if (a == scsf_pkg::ADDR_FLIP) begin
               flip_lvl = d[7];
            end
         end
         scsf_pkg::CMD_SOUND_WR: begin
            if (a == scsf_pkg::ADDR_SMP_NUM) begin
               smp_num = d;
            end else if (a == scsf_pkg::ADDR_TRIGGER) begin
               if (d[7]) begin
                  lo_code  = 4'd0;
                  bit_addr = {smp_num, 8'h00};
               end
               mute_lvl = ~d[7];
            end
         end
         scsf_pkg::CMD_SOUND_RD: begin
            if (a == scsf_pkg::ADDR_CODE_RD) r.read_data = {lo_code, hi_code};
         end
         scsf_pkg::CMD_TICK: begin
            // Send MSB of each byte first; let the address wrap at 16 bits.
            idx           = bit_addr[15:3];
            r.cvsd_bit    = rom_img[idx][3'd7 - bit_addr[2:0]];
            r.cvsd_strobe = 1'b1;
            bit_addr      = bit_addr + 16'd1;
         end
         scsf_pkg::CMD_ROM_LOAD: begin
            if (a < ROM_BYTES) begin
               rom_img[a[12:0]]    = d;
               rom_loaded[a[12:0]] = 1'b1;
            end
         end
         default: ;
      endcase
      r.mute = mute_lvl;
      r.flip = flip_lvl;
      return r;
   endfunction

   function automatic stim_row_type stim_row(input logic [2:0]        c,
                                             input logic [15:0]       a,
                                             input logic [7:0]        d,
                                             input bit                known = 1'b0,
                                             input scsf_pkg::out_type want = '0);
      stim_row_type s;
      s.cmd   = c;
      s.addr  = a;
      s.data  = d;
      s.known = known;
      s.want  = want;
      return s;
   endfunction

   // Favor single set bits so every code value comes up often.
   function automatic logic [7:0] sparse_byte();
      if ($urandom_range(2) == 0) return 8'(1 << $urandom_range(7));
      return 8'($urandom);
   endfunction

   // Present one item, hold it until the transfer, then book its result.
   // Valid is touched once per falling edge: either dropped for an idle
   // cycle or raised with the new payload.
   task automatic send_item(input logic [2:0]        c,
                            input logic [15:0]       a,
                            input logic [7:0]        d,
                            input bit                known = 1'b0,
                            input scsf_pkg::out_type want = '0);
      scsf_pkg::out_type got;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= c;
      req_chan.bus_address <= a;
      req_chan.bus_data    <= d;
      do @(posedge clock); while (!req_chan.ready);
      got = sound_link_result(c, a, d);
      due_results.push_back(known ? want : got);
      items_sent++;
   endtask

   // Tick only over loaded ROM bytes: load the byte under the bit address
   // first if playback has walked onto fresh ground.
   task automatic send_tick(input logic [15:0] a, input logic [7:0] d);
      if (!rom_loaded[bit_addr[15:3]])
         send_item(scsf_pkg::CMD_ROM_LOAD, {3'b000, bit_addr[15:3]}, 8'($urandom));
      send_item(scsf_pkg::CMD_TICK, a, d);
   endtask

   function automatic void check_field(input string       name,
                                       input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Clock and receiver.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stall at the phase's rate, sampled on the falling edge.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare each result transfer, field by field, with the oldest one owed.
   always @(posedge clock) begin : check_results
      scsf_pkg::out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected result, expected none, actual %0h",
                     $time, {rsp_chan.read_data, rsp_chan.cvsd_bit,
                             rsp_chan.cvsd_strobe, rsp_chan.mute, rsp_chan.flip});
         end else begin
            want = due_results.pop_front();
            check_field("read_data",   want.read_data,   rsp_chan.read_data);
            check_field("cvsd_bit",    want.cvsd_bit,    rsp_chan.cvsd_bit);
            check_field("cvsd_strobe", want.cvsd_strobe, rsp_chan.cvsd_strobe);
            check_field("mute",        want.mute,        rsp_chan.mute);
            check_field("flip",        want.flip,        rsp_chan.flip);
         end
      end
   end

   // Watchdog: stop a hung run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0]  num;
      logic [7:0]  d;
      logic [15:0] a;
      logic [2:0]  c;
      int          runs;
      int          pick;
      int          target;
      bit          wrap_done;

      // Reset and initial levels on every request input.
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = scsf_pkg::CMD_MAIN_WR;
      req_chan.bus_address = 16'h0000;
      req_chan.bus_data    = 8'h00;

      // Predictor starts from the reset state; ROM starts empty.
      cmd_word       = '0;
      prev_cmd_word  = '0;
      hi_code        = '0;
      lo_code        = '0;
      smp_num        = '0;
      bit_addr       = '0;
      mute_lvl       = 1'b1;
      flip_lvl       = 1'b0;
      items_sent     = 0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      wrap_done      = 1'b0;
      foreach (rom_loaded[k]) rom_loaded[k] = 1'b0;

      // Hold reset, then release it on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset state, ROM extremes, both codes through their
      // corner cases, flip, trigger and the no-op commands.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'h00, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_ROM_LOAD, 16'h0000, 8'ha5, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_ROM_LOAD, 16'h1fe0, 8'h3c, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_ROM_LOAD, 16'h1fff, 8'h81, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      // Load beyond the ROM: dropped.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_ROM_LOAD, 16'hffff, 8'hff, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      // First two bits of byte 0 (0xa5), MSB first.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_TICK, 16'hffff, 8'hff, 1'b1,
                                  {8'h00, 1'b1, 1'b1, 1'b1, 1'b0}));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1,
                                  {8'h00, 1'b0, 1'b1, 1'b1, 1'b0}));
      // Read of the wrong address returns zero.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, 16'h7001, 8'hff, 1'b1,
                                  {8'h00, 1'b0, 1'b0, 1'b1, 1'b0}));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_HI, 8'hff));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_LO, 8'h3f));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'h00));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_LO, 8'h01));
      // Same low bits as the previous command: low code holds.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_LO, 8'h01));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'h00));
      // No bit set in 6-15: high code drops to zero.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_HI, 8'h00));
      // Low bits zero: low code holds; bit 6 as the lowest set bit gives the top high code.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_LO, 8'hc0));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'h00));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_FLIP, 8'h80));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_MAIN_WR, 16'h1234, 8'h55));
      // Trigger the last sample: playback starts at byte 0x1fe0.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_WR, scsf_pkg::ADDR_SMP_NUM, LAST_SAMPLE));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_WR, scsf_pkg::ADDR_TRIGGER, 8'h80));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_TICK, 16'h0000, 8'h00));
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'h00));
      // Trigger write without bit 7: mute only, no restart.
      dir_rows.push_back(stim_row(scsf_pkg::CMD_SOUND_WR, scsf_pkg::ADDR_TRIGGER, 8'h7f));
      dir_rows.push_back(stim_row(CMD_RSVD5, 16'hffff, 8'hff));
      dir_rows.push_back(stim_row(CMD_RSVD7, 16'h0000, 8'h00));

      foreach (dir_rows[k])
         send_item(dir_rows[k].cmd, dir_rows[k].addr, dir_rows[k].data,
                   dir_rows[k].known, dir_rows[k].want);

      // Random part, one idling pattern per phase.
      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = send_idle_by_phase[ph];
         stall_pct     = stall_by_phase[ph];
         target        = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               // Command handshake: high byte (sometimes), low byte, code read.
               if ($urandom_range(1))
                  send_item(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_HI, sparse_byte());
               d = ($urandom_range(3) == 0) ? cmd_word[7:0] : sparse_byte();
               send_item(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_CMD_LO, d);
               send_item(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'($urandom));
            end else if (pick < 60) begin
               // Playback: latch a sample, trigger, then run the ticks.
               num = ($urandom_range(5) == 0) ? LAST_SAMPLE : 8'($urandom);
               send_item(scsf_pkg::CMD_SOUND_WR, scsf_pkg::ADDR_SMP_NUM, num);
               d = 8'($urandom);
               if ($urandom_range(4) != 0) d[7] = 1'b1;
               send_item(scsf_pkg::CMD_SOUND_WR, scsf_pkg::ADDR_TRIGGER, d);
               // Walk across the address wrap once in the whole test.
               if (num == LAST_SAMPLE && !wrap_done) begin
                  runs      = WRAP_TICKS;
                  wrap_done = 1'b1;
               end else begin
                  runs = $urandom_range(4, 40);
               end
               repeat (runs) begin
                  if ($urandom_range(9) == 0)
                     send_item(scsf_pkg::CMD_SOUND_RD, scsf_pkg::ADDR_CODE_RD, 8'($urandom));
                  send_tick(16'($urandom), 8'($urandom));
               end
            end else if (pick < 68) begin
               send_item(scsf_pkg::CMD_MAIN_WR, scsf_pkg::ADDR_FLIP, 8'($urandom));
            end else begin
               // Noise: any command, known or random address, random data.
               c = 3'($urandom_range(7));
               a = $urandom_range(1) ? bus_addr_pool[$urandom_range(5)] : 16'($urandom);
               d = 8'($urandom);
               if (c == scsf_pkg::CMD_ROM_LOAD && $urandom_range(1))
                  a = 16'($urandom_range(ROM_BYTES - 1));
               if (c == scsf_pkg::CMD_TICK) send_tick(a, d);
               else                         send_item(c, a, d);
            end
         end
      end

      // Drop valid, drain what is owed, then allow the pipeline to settle.
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
